// ===== rtl/core/rotated_two_plane_pixel_writer_core_assert.svh =====
// assertion macros used by the pixel writer rtl
`ifndef ROTATED_TWO_PLANE_PIXEL_WRITER_CORE_ASSERT_SVH
`define ROTATED_TWO_PLANE_PIXEL_WRITER_CORE_ASSERT_SVH

// same-cycle implication, off during reset
`define RTPW_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rtpw assertion failed");

// next-cycle implication, off during reset
`define RTPW_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rtpw assertion failed");

`endif

// ===== rtl/core/rtpw_pkg.sv =====
// shared types and constants of the two-plane pixel writer
`default_nettype none
package rtpw_pkg;

  localparam int PANEL_WIDTH  = 880;
  localparam int PANEL_HEIGHT = 528;
  localparam int ROW_BYTES    = (PANEL_WIDTH + 7) / 8;
  localparam int PLANE_BYTES  = ROW_BYTES * PANEL_HEIGHT;

  localparam int ADDR_W  = $clog2(PLANE_BYTES);
  localparam int XY_W    = 10;
  localparam int PX_W    = $clog2(PANEL_WIDTH);
  localparam int PY_W    = $clog2(PANEL_HEIGHT);
  localparam int COORD_W = $clog2(PANEL_WIDTH + 1024) + 1;
  localparam int WORD_W  = 16;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic signed [COORD_W-1:0] PX_LAST = COORD_W'(PANEL_WIDTH - 1);
  localparam logic signed [COORD_W-1:0] PY_LAST = COORD_W'(PANEL_HEIGHT - 1);
  localparam logic signed [COORD_W-1:0] PX_LIM  = COORD_W'(PANEL_WIDTH);
  localparam logic signed [COORD_W-1:0] PY_LIM  = COORD_W'(PANEL_HEIGHT);

  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(PLANE_BYTES - 1);
  localparam logic [ADDR_W-1:0] ADDR_LIM  = ADDR_W'(PLANE_BYTES);

  localparam logic [7:0] BIT_MSB   = 8'h80;
  localparam logic [7:0] BYTE_ONES = 8'hFF;
  localparam logic [7:0] BYTE_ZERO = 8'h00;

  localparam logic [9:0] LWIDTH_RST  = 10'd880;
  localparam logic [9:0] LHEIGHT_RST = 10'd528;

  localparam int MIR_H = 0;
  localparam int MIR_V = 1;

  typedef enum logic [1:0] {
    MODE_DRAW = 2'd0,
    MODE_FILL = 2'd1,
    MODE_READ = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    COL_BLACK = 2'd0,
    COL_WHITE = 2'd1,
    COL_RED   = 2'd2,
    COL_CLEAR = 2'd3
  } colour_t;

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_t;

  typedef enum logic [1:0] {
    REG_ROTATION  = 2'd0,
    REG_MIRRORING = 2'd1,
    REG_LWIDTH    = 2'd2,
    REG_LHEIGHT   = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_XFORM,
    ST_ADDR,
    ST_MODIFY,
    ST_RDOUT,
    ST_FILL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic            drop;
    logic [PX_W-1:0] px;
    logic [PY_W-1:0] py;
  } xform_t;

  typedef struct packed {
    logic [1:0] rotation;
    logic [1:0] mirroring;
    logic [9:0] logical_width;
    logic [9:0] logical_height;
  } cfg_t;

endpackage
`default_nettype wire

// ===== rtl/core/rtpw_cmd_if.sv =====
// input item channel of the pixel writer
`default_nettype none
interface rtpw_cmd_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                mode;
  logic [9:0]                x_coord;
  logic [9:0]                y_coord;
  logic [1:0]                colour;
  logic [rtpw_pkg::ADDR_W-1:0] byte_addr;

  modport source (output valid, mode, x_coord, y_coord, colour, byte_addr, input ready);
  modport sink (input valid, mode, x_coord, y_coord, colour, byte_addr, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/rtpw_res_if.sv =====
// result item channel of the pixel writer
`default_nettype none
interface rtpw_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] black_byte;
  logic [7:0] red_byte;
  logic       rejected;

  modport source (output valid, black_byte, red_byte, rejected, input ready);
  modport sink (input valid, black_byte, red_byte, rejected, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/rtpw_ram.sv =====
// generic single-write single-read ram with registered read data
`default_nettype none
module rtpw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/rtpw_xform.sv =====
// logical bound check, rotation, mirroring and panel bound check
`default_nettype none
module rtpw_xform (
  input  wire logic [rtpw_pkg::XY_W-1:0] x_coord,
  input  wire logic [rtpw_pkg::XY_W-1:0] y_coord,
  input  wire rtpw_pkg::cfg_t            cfg,
  output      rtpw_pkg::xform_t          xf
);

  logic signed [rtpw_pkg::COORD_W-1:0] cx, cy, rx, ry, mx, my;
  logic in_logical, in_panel;

  always_comb begin
    cx = rtpw_pkg::COORD_W'(x_coord);
    cy = rtpw_pkg::COORD_W'(y_coord);
    unique case (cfg.rotation)
      rtpw_pkg::ROT_0: begin
        rx = cx;
        ry = cy;
      end
      rtpw_pkg::ROT_90: begin
        rx = rtpw_pkg::PX_LAST - cy;
        ry = cx;
      end
      rtpw_pkg::ROT_180: begin
        rx = rtpw_pkg::PX_LAST - cx;
        ry = rtpw_pkg::PY_LAST - cy;
      end
      default: begin
        rx = cy;
        ry = rtpw_pkg::PY_LAST - cx;
      end
    endcase
    mx = cfg.mirroring[rtpw_pkg::MIR_H] ? rtpw_pkg::PX_LAST - rx : rx;
    my = cfg.mirroring[rtpw_pkg::MIR_V] ? rtpw_pkg::PY_LAST - ry : ry;
    in_logical = (x_coord < cfg.logical_width) && (y_coord < cfg.logical_height);
    in_panel = (mx >= 0) && (mx < rtpw_pkg::PX_LIM) && (my >= 0) && (my < rtpw_pkg::PY_LIM);
    xf.drop = !(in_logical && in_panel);
    xf.px = mx[rtpw_pkg::PX_W-1:0];
    xf.py = my[rtpw_pkg::PY_W-1:0];
  end

endmodule
`default_nettype wire

// ===== rtl/core/rotated_two_plane_pixel_writer_core.sv =====
// top level of the rotated two-plane pixel writer
//
//  channel  dir  handshake                    payload
//  cmd      in   valid / ready                mode x_coord y_coord colour byte_addr
//  res      out  valid / ready                black_byte red_byte rejected
//  apb      in   psel penable pwrite pready   paddr pwdata prdata
//
// one item at a time through a sequencer around a 16-bit {black, red} plane ram
// draw: transform, then address multiply and ram read, then write back, then result
// read: ram read from the transform state, readout, then result; fill: one ram write per byte
// reset clears control and config only; plane contents stay undefined until filled
// a new item is taken while the result register still waits; the done state holds on stall
`default_nettype none
`include "rotated_two_plane_pixel_writer_core_assert.svh"
module rotated_two_plane_pixel_writer_core (
  input  wire logic                         clk,
  input  wire logic                         rst,
  rtpw_cmd_if.sink                          cmd,
  rtpw_res_if.source                        res,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [rtpw_pkg::PADDR_W-1:0] paddr,
  input  wire logic [rtpw_pkg::PDATA_W-1:0] pwdata,
  output      logic [rtpw_pkg::PDATA_W-1:0] prdata,
  output      logic                         pready
);

  rtpw_pkg::state_t state, state_next;
  rtpw_pkg::cfg_t   cfg;
  rtpw_pkg::xform_t xf;

  logic [1:0]                  item_mode;
  logic [rtpw_pkg::XY_W-1:0]   item_x;
  logic [rtpw_pkg::XY_W-1:0]   item_y;
  logic [1:0]                  item_colour;
  logic [rtpw_pkg::ADDR_W-1:0] item_addr;

  logic                        drop;
  logic [rtpw_pkg::PX_W-1:0]   px;
  logic [rtpw_pkg::PY_W-1:0]   py;
  logic [rtpw_pkg::ADDR_W-1:0] pix_addr;
  logic [rtpw_pkg::ADDR_W-1:0] calc_addr;
  logic [rtpw_pkg::ADDR_W-1:0] fill_position;
  logic [7:0]                  res_black, res_red;
  logic                        res_rej;

  logic                        out_free;
  logic                        cfg_wr;
  logic [7:0]                  bit_mask;
  logic [7:0]                  mod_black, mod_red;
  logic [7:0]                  fill_black, fill_red;

  logic                        ram_wr_en, ram_rd_en;
  logic [rtpw_pkg::ADDR_W-1:0] ram_wr_addr, ram_rd_addr;
  logic [rtpw_pkg::WORD_W-1:0] ram_wr_data, ram_rd_data;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rotation       <= '0;
      cfg.mirroring      <= '0;
      cfg.logical_width  <= rtpw_pkg::LWIDTH_RST;
      cfg.logical_height <= rtpw_pkg::LHEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        rtpw_pkg::REG_ROTATION:  cfg.rotation       <= pwdata[1:0];
        rtpw_pkg::REG_MIRRORING: cfg.mirroring      <= pwdata[1:0];
        rtpw_pkg::REG_LWIDTH:    cfg.logical_width  <= pwdata[9:0];
        default:                 cfg.logical_height <= pwdata[9:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      rtpw_pkg::REG_ROTATION:  prdata = rtpw_pkg::PDATA_W'(cfg.rotation);
      rtpw_pkg::REG_MIRRORING: prdata = rtpw_pkg::PDATA_W'(cfg.mirroring);
      rtpw_pkg::REG_LWIDTH:    prdata = rtpw_pkg::PDATA_W'(cfg.logical_width);
      default:                 prdata = rtpw_pkg::PDATA_W'(cfg.logical_height);
    endcase
  end

  rtpw_xform u_xform (
    .x_coord (item_x),
    .y_coord (item_y),
    .cfg     (cfg),
    .xf      (xf)
  );

  rtpw_ram #(
    .WIDTH (rtpw_pkg::WORD_W),
    .DEPTH (rtpw_pkg::PLANE_BYTES)
  ) u_plane_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign out_free  = !res.valid || res.ready;
  assign calc_addr = rtpw_pkg::ADDR_W'(px >> 3)
                   + rtpw_pkg::ADDR_W'(py * rtpw_pkg::ROW_BYTES);
  assign bit_mask  = rtpw_pkg::BIT_MSB >> px[2:0];

  // plane bit update for one pixel
  always_comb begin
    mod_black = ram_rd_data[15:8];
    mod_red   = ram_rd_data[7:0];
    unique case (item_colour)
      rtpw_pkg::COL_BLACK: begin
        mod_black = ram_rd_data[15:8] & ~bit_mask;
        mod_red   = ram_rd_data[7:0] | bit_mask;
      end
      rtpw_pkg::COL_WHITE: begin
        mod_black = ram_rd_data[15:8] | bit_mask;
        mod_red   = ram_rd_data[7:0] | bit_mask;
      end
      rtpw_pkg::COL_RED: begin
        mod_black = ram_rd_data[15:8] | bit_mask;
        mod_red   = ram_rd_data[7:0] & ~bit_mask;
      end
      default: ;
    endcase
  end

  always_comb begin
    unique case (item_colour)
      rtpw_pkg::COL_BLACK: begin
        fill_black = rtpw_pkg::BYTE_ZERO;
        fill_red   = rtpw_pkg::BYTE_ONES;
      end
      rtpw_pkg::COL_WHITE: begin
        fill_black = rtpw_pkg::BYTE_ONES;
        fill_red   = rtpw_pkg::BYTE_ONES;
      end
      default: begin
        fill_black = rtpw_pkg::BYTE_ONES;
        fill_red   = rtpw_pkg::BYTE_ZERO;
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      rtpw_pkg::ST_IDLE: begin
        if (cmd.valid) state_next = rtpw_pkg::ST_XFORM;
      end
      rtpw_pkg::ST_XFORM: begin
        unique case (item_mode)
          rtpw_pkg::MODE_DRAW: begin
            if (xf.drop || item_colour == rtpw_pkg::COL_CLEAR) state_next = rtpw_pkg::ST_DONE;
            else state_next = rtpw_pkg::ST_ADDR;
          end
          rtpw_pkg::MODE_FILL: begin
            if (item_colour == rtpw_pkg::COL_CLEAR) state_next = rtpw_pkg::ST_DONE;
            else state_next = rtpw_pkg::ST_FILL;
          end
          rtpw_pkg::MODE_READ: begin
            if (item_addr < rtpw_pkg::ADDR_LIM) state_next = rtpw_pkg::ST_RDOUT;
            else state_next = rtpw_pkg::ST_DONE;
          end
          default: state_next = rtpw_pkg::ST_DONE;
        endcase
      end
      rtpw_pkg::ST_ADDR:   state_next = rtpw_pkg::ST_MODIFY;
      rtpw_pkg::ST_MODIFY: state_next = rtpw_pkg::ST_DONE;
      rtpw_pkg::ST_RDOUT:  state_next = rtpw_pkg::ST_DONE;
      rtpw_pkg::ST_FILL: begin
        if (fill_position == rtpw_pkg::ADDR_LAST) state_next = rtpw_pkg::ST_DONE;
      end
      rtpw_pkg::ST_DONE: begin
        if (out_free) state_next = rtpw_pkg::ST_IDLE;
      end
      default: state_next = rtpw_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    cmd.ready   = 1'b0;
    ram_rd_en   = 1'b0;
    ram_rd_addr = item_addr;
    ram_wr_en   = 1'b0;
    ram_wr_addr = pix_addr;
    ram_wr_data = {mod_black, mod_red};
    unique case (state)
      rtpw_pkg::ST_IDLE: cmd.ready = 1'b1;
      rtpw_pkg::ST_XFORM: begin
        ram_rd_en = (item_mode == rtpw_pkg::MODE_READ) && (item_addr < rtpw_pkg::ADDR_LIM);
      end
      rtpw_pkg::ST_ADDR: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = calc_addr;
      end
      rtpw_pkg::ST_MODIFY: ram_wr_en = 1'b1;
      rtpw_pkg::ST_FILL: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = fill_position;
        ram_wr_data = {fill_black, fill_red};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= rtpw_pkg::ST_IDLE;
      fill_position <= '0;
      res.valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (state == rtpw_pkg::ST_FILL) begin
        fill_position <= (fill_position == rtpw_pkg::ADDR_LAST) ? '0 : fill_position + 1'b1;
      end
      if (state == rtpw_pkg::ST_DONE && out_free) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      item_mode   <= cmd.mode;
      item_x      <= cmd.x_coord;
      item_y      <= cmd.y_coord;
      item_colour <= cmd.colour;
      item_addr   <= cmd.byte_addr;
      res_black   <= '0;
      res_red     <= '0;
      res_rej     <= 1'b0;
    end
    if (state == rtpw_pkg::ST_XFORM) begin
      drop <= xf.drop;
      px   <= xf.px;
      py   <= xf.py;
      if (item_mode == rtpw_pkg::MODE_DRAW) res_rej <= xf.drop;
    end
    if (state == rtpw_pkg::ST_ADDR) pix_addr <= calc_addr;
    if (state == rtpw_pkg::ST_RDOUT) begin
      res_black <= ram_rd_data[15:8];
      res_red   <= ram_rd_data[7:0];
    end
    if (state == rtpw_pkg::ST_DONE && out_free) begin
      res.black_byte <= res_black;
      res.red_byte   <= res_red;
      res.rejected   <= res_rej;
    end
  end

  `RTPW_ASSERT_IMP(a_wr_in_range, clk, rst, ram_wr_en, ram_wr_addr < rtpw_pkg::ADDR_LIM)
  `RTPW_ASSERT_IMP(a_fill_pos_home, clk, rst, state != rtpw_pkg::ST_FILL, fill_position == '0)
  `RTPW_ASSERT_NXT(a_accept_starts, clk, rst, cmd.valid && cmd.ready, state == rtpw_pkg::ST_XFORM)
  `RTPW_ASSERT_NXT(a_result_from_done, clk, rst, !res.valid && state != rtpw_pkg::ST_DONE, !res.valid)
  `RTPW_ASSERT_IMP(a_modify_not_dropped, clk, rst, state == rtpw_pkg::ST_MODIFY, !drop)

endmodule
`default_nettype wire

// ===== tb/tb_rotated_two_plane_pixel_writer_core.sv =====
// testbench for the rotated two-plane pixel writer, checked against a shadow frame buffer
module tb_rotated_two_plane_pixel_writer_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 4_000_000;
  localparam int PHASE_ITEMS   = 150;
  localparam int RANDOM_PHASES = 13;
  localparam int HOLD_CYCLES   = 300;
  localparam int TOUCHED_DEPTH = 64;
  localparam logic [1:0] NO_MIRROR   = 2'b00;
  localparam logic [1:0] MIRROR_BOTH = 2'b11;

  typedef logic [rtpw_pkg::ADDR_W-1:0]  addr_t;
  typedef logic [rtpw_pkg::PADDR_W-1:0] paddr_t;
  typedef logic [rtpw_pkg::PDATA_W-1:0] pdata_t;

  typedef struct packed {
    logic [7:0] black_byte;
    logic [7:0] red_byte;
    logic       rejected;
  } scan_result_t;

  logic   clk;
  logic   rst;
  logic   psel;
  logic   penable;
  logic   pwrite;
  paddr_t paddr;
  pdata_t pwdata;
  pdata_t prdata;
  logic   pready;

  rtpw_cmd_if cmd_ch();
  rtpw_res_if res_ch();

  rotated_two_plane_pixel_writer_core dut (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_ch),
    .res     (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [7:0]     shadow_black [rtpw_pkg::PLANE_BYTES];
  logic [7:0]     shadow_red [rtpw_pkg::PLANE_BYTES];
  rtpw_pkg::rot_t rot_cfg     = rtpw_pkg::ROT_0;
  logic [1:0]     mir_cfg     = NO_MIRROR;
  logic [9:0]     lwidth_cfg  = rtpw_pkg::LWIDTH_RST;
  logic [9:0]     lheight_cfg = rtpw_pkg::LHEIGHT_RST;
  scan_result_t   expected_results[$];
  int             touched_addrs[$];
  int             fail_count      = 0;
  int             cycle_count     = 0;
  int             hold_len        = 0;
  int             fills_left      = 2;
  bit             hold_active     = 1'b0;
  bit             sender_gaps     = 1'b1;
  bit             receiver_stalls = 1'b1;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic scan_result_t predict_scan_result(rtpw_pkg::mode_t m, logic [9:0] x,
                                                       logic [9:0] y, rtpw_pkg::colour_t c,
                                                       addr_t a);
    scan_result_t r;
    int px;
    int py;
    int addr;
    logic [7:0] mask;
    logic [7:0] fb;
    logic [7:0] fr;
    r = '0;
    px = 0;
    py = 0;
    fb = rtpw_pkg::BYTE_ZERO;
    fr = rtpw_pkg::BYTE_ZERO;
    case (m)
      rtpw_pkg::MODE_DRAW: begin
        if (x >= lwidth_cfg || y >= lheight_cfg) begin
          r.rejected = 1'b1;
        end else begin
          case (rot_cfg)
            rtpw_pkg::ROT_0: begin
              px = int'(x);
              py = int'(y);
            end
            rtpw_pkg::ROT_90: begin
              px = rtpw_pkg::PANEL_WIDTH - int'(y) - 1;
              py = int'(x);
            end
            rtpw_pkg::ROT_180: begin
              px = rtpw_pkg::PANEL_WIDTH - int'(x) - 1;
              py = rtpw_pkg::PANEL_HEIGHT - int'(y) - 1;
            end
            default: begin
              px = int'(y);
              py = rtpw_pkg::PANEL_HEIGHT - int'(x) - 1;
            end
          endcase
          if (mir_cfg[rtpw_pkg::MIR_H]) px = rtpw_pkg::PANEL_WIDTH - px - 1;
          if (mir_cfg[rtpw_pkg::MIR_V]) py = rtpw_pkg::PANEL_HEIGHT - py - 1;
          if (px < 0 || px >= rtpw_pkg::PANEL_WIDTH ||
              py < 0 || py >= rtpw_pkg::PANEL_HEIGHT) begin
            r.rejected = 1'b1;
          end else begin
            addr = px / 8 + py * rtpw_pkg::ROW_BYTES;
            mask = rtpw_pkg::BIT_MSB >> (px % 8);
            case (c)
              rtpw_pkg::COL_BLACK: begin
                shadow_black[addr] = shadow_black[addr] & ~mask;
                shadow_red[addr]   = shadow_red[addr] | mask;
              end
              rtpw_pkg::COL_WHITE: begin
                shadow_black[addr] = shadow_black[addr] | mask;
                shadow_red[addr]   = shadow_red[addr] | mask;
              end
              rtpw_pkg::COL_RED: begin
                shadow_black[addr] = shadow_black[addr] | mask;
                shadow_red[addr]   = shadow_red[addr] & ~mask;
              end
              default: ;
            endcase
            touched_addrs.push_back(addr);
            if (touched_addrs.size() > TOUCHED_DEPTH) void'(touched_addrs.pop_front());
          end
        end
      end
      rtpw_pkg::MODE_FILL: begin
        case (c)
          rtpw_pkg::COL_BLACK: begin
            fb = rtpw_pkg::BYTE_ZERO;
            fr = rtpw_pkg::BYTE_ONES;
          end
          rtpw_pkg::COL_WHITE: begin
            fb = rtpw_pkg::BYTE_ONES;
            fr = rtpw_pkg::BYTE_ONES;
          end
          default: begin
            fb = rtpw_pkg::BYTE_ONES;
            fr = rtpw_pkg::BYTE_ZERO;
          end
        endcase
        if (c != rtpw_pkg::COL_CLEAR) begin
          for (int i = 0; i < rtpw_pkg::PLANE_BYTES; i++) begin
            shadow_black[i] = fb;
            shadow_red[i]   = fr;
          end
        end
      end
      rtpw_pkg::MODE_READ: begin
        if (int'(a) < rtpw_pkg::PLANE_BYTES) begin
          r.black_byte = shadow_black[a];
          r.red_byte   = shadow_red[a];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    scan_result_t got;
    scan_result_t want;
    if (!rst) begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        expected_results.push_back(predict_scan_result(rtpw_pkg::mode_t'(cmd_ch.mode),
                                                       cmd_ch.x_coord, cmd_ch.y_coord,
                                                       rtpw_pkg::colour_t'(cmd_ch.colour),
                                                       cmd_ch.byte_addr));
      end
      if (res_ch.valid && res_ch.ready) begin
        got = {res_ch.black_byte, res_ch.red_byte, res_ch.rejected};
        if (expected_results.size() == 0) begin
          $error("result item with none expected: black_byte %0h red_byte %0h rejected %0b",
                 got.black_byte, got.red_byte, got.rejected);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.black_byte !== want.black_byte) begin
            $error("black_byte: expected %0h, actual %0h", want.black_byte, got.black_byte);
            fail_count++;
          end
          if (got.red_byte !== want.red_byte) begin
            $error("red_byte: expected %0h, actual %0h", want.red_byte, got.red_byte);
            fail_count++;
          end
          if (got.rejected !== want.rejected) begin
            $error("rejected: expected %0b, actual %0b", want.rejected, got.rejected);
            fail_count++;
          end
        end
      end
    end
  end

  // result side: random stalls, plus a long hold on request
  initial begin
    forever begin
      if (hold_len > 0) begin
        res_ch.ready <= 1'b0;
        hold_active = 1'b1;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
        hold_active = 1'b0;
      end else if (receiver_stalls && $urandom_range(0, 3) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        res_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
  end

  task automatic send_item(rtpw_pkg::mode_t m, logic [9:0] x, logic [9:0] y,
                           rtpw_pkg::colour_t c, addr_t a);
    int gap;
    gap = (sender_gaps && $urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid     <= 1'b1;
    cmd_ch.mode      <= m;
    cmd_ch.x_coord   <= x;
    cmd_ch.y_coord   <= y;
    cmd_ch.colour    <= c;
    cmd_ch.byte_addr <= a;
    do @(posedge clk); while (!cmd_ch.ready);
  endtask

  task automatic drain_results();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  task automatic write_reg(rtpw_pkg::reg_idx_t idx, logic [31:0] val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= paddr_t'({idx, 2'b00});
    pwdata  <= pdata_t'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      rtpw_pkg::REG_ROTATION:  rot_cfg     = rtpw_pkg::rot_t'(val[1:0]);
      rtpw_pkg::REG_MIRRORING: mir_cfg     = val[1:0];
      rtpw_pkg::REG_LWIDTH:    lwidth_cfg  = val[9:0];
      default:                 lheight_cfg = val[9:0];
    endcase
  endtask

  task automatic set_config(rtpw_pkg::rot_t r, logic [1:0] m, logic [9:0] w, logic [9:0] h);
    write_reg(rtpw_pkg::REG_ROTATION, 32'(r));
    write_reg(rtpw_pkg::REG_MIRRORING, 32'(m));
    write_reg(rtpw_pkg::REG_LWIDTH, 32'(w));
    write_reg(rtpw_pkg::REG_LHEIGHT, 32'(h));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [9:0] pick_coord(logic [9:0] lim);
    int r;
    r = $urandom_range(0, 99);
    if (lim == 0 || r >= 90) return 10'($urandom_range(0, 1023));
    if (r < 25) return 10'($urandom_range(0, (lim > 16) ? 15 : int'(lim) - 1));
    if (r < 30) return lim - 1;
    if (r < 35) return lim;
    return 10'($urandom_range(0, int'(lim) - 1));
  endfunction

  function automatic logic [9:0] pick_limit(int dflt);
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return 10'd0;
    if (r < 14) return 10'd1;
    if (r < 30) return 10'd1023;
    if (r < 45) return 10'(dflt);
    return 10'($urandom_range(1, 1023));
  endfunction

  task automatic send_random_item();
    int pick;
    int sel;
    rtpw_pkg::mode_t m;
    rtpw_pkg::colour_t c;
    logic [9:0] x;
    logic [9:0] y;
    addr_t a;
    pick = $urandom_range(0, 99);
    c = rtpw_pkg::colour_t'($urandom_range(0, 3));
    x = 10'($urandom_range(0, 1023));
    y = 10'($urandom_range(0, 1023));
    a = addr_t'($urandom_range(0, 65535));
    if (pick < 2 && fills_left > 0) begin
      m = rtpw_pkg::MODE_FILL;
      fills_left--;
    end else if (pick < 60) begin
      m = rtpw_pkg::MODE_DRAW;
      x = pick_coord(lwidth_cfg);
      y = pick_coord(lheight_cfg);
    end else if (pick < 95) begin
      m = rtpw_pkg::MODE_READ;
      sel = $urandom_range(0, 99);
      if (touched_addrs.size() > 0 && sel < 60)
        a = addr_t'(touched_addrs[$urandom_range(0, touched_addrs.size() - 1)]);
      else if (sel < 90)
        a = addr_t'($urandom_range(0, rtpw_pkg::PLANE_BYTES - 1));
    end else begin
      m = rtpw_pkg::MODE_NONE;
    end
    send_item(m, x, y, c, a);
  endtask

  task automatic test_fill_and_scanout();
    send_item(rtpw_pkg::MODE_FILL, 10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
              rtpw_pkg::COL_WHITE, addr_t'($urandom_range(0, 65535)));
    send_item(rtpw_pkg::MODE_READ, '0, '0, rtpw_pkg::COL_BLACK, '0);
    send_item(rtpw_pkg::MODE_READ, '1, '1, rtpw_pkg::COL_CLEAR, rtpw_pkg::ADDR_LAST);
    send_item(rtpw_pkg::MODE_READ, '0, '1, rtpw_pkg::COL_RED, rtpw_pkg::ADDR_LIM);
    send_item(rtpw_pkg::MODE_READ, '1, '0, rtpw_pkg::COL_WHITE, '1);
    send_item(rtpw_pkg::MODE_NONE, '1, '1, rtpw_pkg::COL_CLEAR, '1);
    drain_results();
  endtask

  task automatic test_draw_colours();
    send_item(rtpw_pkg::MODE_DRAW, 10'd0, 10'd0, rtpw_pkg::COL_BLACK, '1);
    send_item(rtpw_pkg::MODE_DRAW, 10'd1, 10'd0, rtpw_pkg::COL_RED, '0);
    send_item(rtpw_pkg::MODE_DRAW, 10'd2, 10'd0, rtpw_pkg::COL_WHITE, '1);
    send_item(rtpw_pkg::MODE_DRAW, 10'd3, 10'd0, rtpw_pkg::COL_CLEAR, '0);
    send_item(rtpw_pkg::MODE_READ, '1, '1, rtpw_pkg::COL_CLEAR, '0);
    send_item(rtpw_pkg::MODE_DRAW, 10'd879, 10'd527, rtpw_pkg::COL_RED, '0);
    send_item(rtpw_pkg::MODE_READ, '0, '0, rtpw_pkg::COL_BLACK, rtpw_pkg::ADDR_LAST);
    drain_results();
  endtask

  task automatic test_bounds();
    send_item(rtpw_pkg::MODE_DRAW, 10'd880, 10'd0, rtpw_pkg::COL_BLACK, '0);
    send_item(rtpw_pkg::MODE_DRAW, 10'd0, 10'd528, rtpw_pkg::COL_BLACK, '0);
    send_item(rtpw_pkg::MODE_DRAW, 10'd1023, 10'd1023, rtpw_pkg::COL_RED, '1);
    drain_results();
    // panel bounds after rotation and mirroring
    set_config(rtpw_pkg::ROT_90, MIRROR_BOTH, 10'd1023, 10'd1023);
    send_item(rtpw_pkg::MODE_DRAW, 10'd0, 10'd1023, rtpw_pkg::COL_BLACK, '0);
    send_item(rtpw_pkg::MODE_DRAW, 10'd879, 10'd879, rtpw_pkg::COL_BLACK, '0);
    send_item(rtpw_pkg::MODE_DRAW, 10'd527, 10'd0, rtpw_pkg::COL_BLACK, '0);
    send_item(rtpw_pkg::MODE_READ, '0, '0, rtpw_pkg::COL_BLACK, '0);
    drain_results();
    set_config(rtpw_pkg::ROT_0, NO_MIRROR, 10'd0, 10'd0);
    send_item(rtpw_pkg::MODE_DRAW, 10'd0, 10'd0, rtpw_pkg::COL_WHITE, '0);
    drain_results();
    set_config(rtpw_pkg::ROT_0, NO_MIRROR, 10'd1, 10'd1);
    send_item(rtpw_pkg::MODE_DRAW, 10'd0, 10'd0, rtpw_pkg::COL_WHITE, '0);
    send_item(rtpw_pkg::MODE_DRAW, 10'd1, 10'd0, rtpw_pkg::COL_BLACK, '0);
    send_item(rtpw_pkg::MODE_DRAW, 10'd0, 10'd1, rtpw_pkg::COL_BLACK, '0);
    drain_results();
  endtask

  task automatic test_fill_colours();
    send_item(rtpw_pkg::MODE_FILL, '0, '0, rtpw_pkg::COL_RED, '0);
    send_item(rtpw_pkg::MODE_FILL, '1, '1, rtpw_pkg::COL_CLEAR, '1);
    send_item(rtpw_pkg::MODE_READ, '0, '0, rtpw_pkg::COL_BLACK, addr_t'(5));
    send_item(rtpw_pkg::MODE_FILL, '0, '1, rtpw_pkg::COL_BLACK, '0);
    send_item(rtpw_pkg::MODE_READ, '1, '0, rtpw_pkg::COL_BLACK, addr_t'(5));
    drain_results();
  endtask

  task automatic test_result_backpressure();
    sender_gaps = 1'b0;
    hold_len = HOLD_CYCLES;
    wait (hold_active);
    for (int i = 0; i < 16; i++)
      send_item((i % 2) ? rtpw_pkg::MODE_READ : rtpw_pkg::MODE_DRAW, 10'(i), 10'(i),
                rtpw_pkg::colour_t'(i % 4), addr_t'(i));
    drain_results();
    sender_gaps = 1'b1;
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == RANDOM_PHASES - 1) begin
        sender_gaps = 1'b0;
        receiver_stalls = 1'b0;
      end
      set_config(rtpw_pkg::rot_t'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                 pick_limit(880), pick_limit(528));
      repeat (PHASE_ITEMS) send_random_item();
      drain_results();
    end
  endtask

  initial begin
    rst              <= 1'b1;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    cmd_ch.valid     <= 1'b0;
    cmd_ch.mode      <= rtpw_pkg::MODE_NONE;
    cmd_ch.x_coord   <= '0;
    cmd_ch.y_coord   <= '0;
    cmd_ch.colour    <= rtpw_pkg::COL_CLEAR;
    cmd_ch.byte_addr <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_fill_and_scanout();
    test_draw_colours();
    test_bounds();
    test_fill_colours();
    test_result_backpressure();
    test_random_traffic();
    drain_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
